// ===== design/dlbp_pkg.sv =====
// Package for the distance LED bar pattern unit.
// Holds field widths, register codes, reset values and the types that the modules share.
// No dependencies.
`default_nettype none

package dlbp_pkg;

   localparam int unsigned LED_COUNT_DEF    = 16;
   localparam int unsigned MAX_DISTANCE_DEF = 200;
   localparam int unsigned GUARD_BAND_DEF   = 10;
   localparam int unsigned FLIP_DEF         = 0;
   localparam int unsigned QUEUE_DEPTH      = 2;

   localparam int DIST_W      = 10;
   localparam int MODE_W      = 3;
   localparam int LEVEL_W     = 8;
   localparam int COLOUR_W    = 8;
   localparam int INDEX_W     = 6;
   localparam int PARK_W      = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int THR_W       = 11;
   localparam int NUM_W       = 18;
   localparam int DEN_W       = 12;
   localparam int SPAN_W      = 7;

   typedef enum logic [MODE_W-1:0] {
      MODE_BAR              = 3'd0,
      MODE_RED_GREEN        = 3'd1,
      MODE_RED_YELLOW_GREEN = 3'd2,
      MODE_STOPLIGHT        = 3'd3,
      MODE_OFF              = 3'd4
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DISPLAY_MODE  = 2'd0,
      CSR_BRIGHTNESS    = 2'd1,
      CSR_PARK_DISTANCE = 2'd2
   } csr_index_type;

   localparam logic [MODE_W-1:0]   DISPLAY_MODE_RESET  = MODE_BAR;
   localparam logic [LEVEL_W-1:0]  BRIGHTNESS_RESET    = 8'd255;
   localparam logic [PARK_W-1:0]   PARK_DISTANCE_RESET = 10'd30;

   localparam logic [COLOUR_W-1:0] COLOUR_FULL = 8'd255;
   localparam logic [COLOUR_W-1:0] COLOUR_NONE = 8'd0;

   typedef struct packed {
      logic [MODE_W-1:0]  display_mode;
      logic [LEVEL_W-1:0] brightness;
      logic [PARK_W-1:0]  park_distance;
   } cfg_type;

   typedef struct packed {
      logic                    is_bar;
      logic [SPAN_W-1:0]       lo;
      logic [SPAN_W-1:0]       hi;
      logic [COLOUR_W-1:0]     red;
      logic [COLOUR_W-1:0]     green;
      logic signed [NUM_W-1:0] num;
      logic signed [DEN_W-1:0] den;
   } desc_type;

endpackage

`default_nettype wire

// ===== design/dlbp_req_if.sv =====
// Request channel of the distance LED bar pattern unit: one distance sample per request.
// Depends on dlbp_pkg.
`default_nettype none

interface dlbp_req_if;
   logic                       valid;
   logic                       ready;
   logic [dlbp_pkg::DIST_W-1:0] distance;

   modport source (output valid, output distance, input ready);
   modport sink (input valid, input distance, output ready);
endinterface

`default_nettype wire

// ===== design/dlbp_rsp_if.sv =====
// Response channel of the distance LED bar pattern unit: one pixel colour per response.
// Depends on dlbp_pkg.
`default_nettype none

interface dlbp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dlbp_pkg::INDEX_W-1:0]  pixel_index;
   logic [dlbp_pkg::COLOUR_W-1:0] red;
   logic [dlbp_pkg::COLOUR_W-1:0] green;
   logic [dlbp_pkg::COLOUR_W-1:0] blue;
   logic [dlbp_pkg::LEVEL_W-1:0]  level;
   logic                         last;

   modport source (output valid, output pixel_index, output red, output green,
                   output blue, output level, output last, input ready);
   modport sink (input valid, input pixel_index, input red, input green,
                 input blue, input level, input last, output ready);
endinterface

`default_nettype wire

// ===== design/dlbp_front.sv =====
// Front end: registers a distance sample, classifies it into a frame descriptor and
// derives the bar colours by reciprocal multiplication. Depends on dlbp_pkg.
`default_nettype none

module dlbp_front #(
   parameter int unsigned LED_COUNT    = dlbp_pkg::LED_COUNT_DEF,
   parameter int unsigned MAX_DISTANCE = dlbp_pkg::MAX_DISTANCE_DEF,
   parameter int unsigned GUARD_BAND   = dlbp_pkg::GUARD_BAND_DEF,
   parameter int unsigned FLIP         = dlbp_pkg::FLIP_DEF
) (
   input  logic               clock,
   input  logic               reset,
   dlbp_req_if.sink           req_if,
   input  dlbp_pkg::cfg_type  cfg,
   output logic               push_valid,
   input  logic               push_ready,
   output dlbp_pkg::desc_type push_desc
);
   import dlbp_pkg::*;

   localparam int STEPS       = 1;
   localparam int DVD_W       = 18;
   localparam int W           = 14;
   localparam int NW          = 22;
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP_W     = 29;
   localparam int PROD_W      = RECIP_SHIFT + COLOUR_W;
   localparam int unsigned STOP_S = (LED_COUNT - 2) / 3;

   localparam logic [SPAN_W-1:0] SPAN_ZERO  = '0;
   localparam logic [SPAN_W-1:0] SPAN_ALL   = SPAN_W'(LED_COUNT);
   localparam logic [SPAN_W-1:0] SPAN_S     = SPAN_W'(STOP_S);
   localparam logic [SPAN_W-1:0] SPAN_2S_M1 = SPAN_W'(2 * STOP_S - 1);
   localparam logic [SPAN_W-1:0] SPAN_3S    = SPAN_W'(3 * STOP_S);
   localparam logic [SPAN_W-1:0] SPAN_3S_M1 = SPAN_W'(3 * STOP_S - 1);

   localparam logic signed [W-1:0]     MAX_S   = W'(MAX_DISTANCE);
   localparam logic signed [NW-1:0]    SAT_LIM = NW'(256 * MAX_DISTANCE);
   localparam logic signed [NUM_W-1:0] LED_M1  = NUM_W'(LED_COUNT - 1);
   localparam logic signed [NUM_W-1:0] MAX_N   = NUM_W'(MAX_DISTANCE);
   localparam logic signed [DEN_W-1:0] MAX_D   = DEN_W'(MAX_DISTANCE);
   localparam logic [RECIP_W-1:0]      RECIP   = RECIP_W'(((64'd1 << RECIP_SHIFT)
                                                 + 64'(MAX_DISTANCE) - 64'd1)
                                                 / 64'(MAX_DISTANCE));

   typedef struct packed {
      logic                zero;
      logic                sat;
      logic [DVD_W-1:0]    dividend;
      logic [COLOUR_W-1:0] quo;
   } div_type;

   typedef struct packed {
      desc_type desc;
      div_type  red_div;
      div_type  green_div;
   } stage_type;

   logic              advance;
   logic              dist_v_ff;
   logic              dist_v_in;
   logic [DIST_W-1:0] dist_ff;
   logic [DIST_W-1:0] dist_in;

   logic [STEPS:0]    pipe_v_ff;
   logic [STEPS:0]    pipe_v_in;
   stage_type         pipe_ff [STEPS+1];
   stage_type         pipe_in [STEPS+1];

   logic [THR_W-1:0]        thr;
   logic signed [W-1:0]     d;
   logic signed [W-1:0]     m2;
   logic signed [W-1:0]     red_x;
   logic signed [NW-1:0]    red_xw;
   logic signed [NW-1:0]    green_xw;
   logic signed [NW-1:0]    red_num;
   logic signed [NW-1:0]    green_num;
   logic signed [NUM_W-1:0] dm;
   logic                    lt_thr;
   logic                    lt_m2;
   logic [PROD_W-1:0]       red_prod;
   logic [PROD_W-1:0]       green_prod;

   assign advance       = !pipe_v_ff[STEPS] || push_ready;
   assign req_if.ready  = advance;
   assign dist_v_in     = req_if.valid;
   assign dist_in       = req_if.distance;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_v_ff <= 1'b0;
         pipe_v_ff <= '0;
      end else if (advance) begin
         dist_v_ff <= dist_v_in;
         pipe_v_ff <= pipe_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff <= dist_in;
         for (int j = 0; j <= STEPS; j++) begin
            pipe_ff[j] <= pipe_in[j];
         end
      end
   end

   assign pipe_v_in = {pipe_v_ff[STEPS-1:0], dist_v_ff};

   // classify
   always_comb begin
      thr       = THR_W'(GUARD_BAND) + THR_W'(cfg.park_distance);
      d         = $signed(W'(dist_ff)) - $signed(W'(thr));
      m2        = MAX_S - $signed(W'(thr));
      red_x     = MAX_S - d;
      red_xw    = NW'(red_x);
      green_xw  = NW'(d);
      red_num   = (red_xw <<< 9) - (red_xw <<< 1);
      green_num = (green_xw <<< 9) - (green_xw <<< 1);
      dm        = $signed(NUM_W'(dist_ff)) - MAX_N;
      lt_thr    = {1'b0, dist_ff} < thr;
      lt_m2     = $signed(W'(dist_ff)) < m2;

      pipe_in[0].desc.is_bar = 1'b0;
      pipe_in[0].desc.lo     = SPAN_ZERO;
      pipe_in[0].desc.hi     = SPAN_ZERO;
      pipe_in[0].desc.red    = COLOUR_NONE;
      pipe_in[0].desc.green  = COLOUR_NONE;
      pipe_in[0].desc.num    = dm * LED_M1;
      pipe_in[0].desc.den    = $signed(DEN_W'(thr)) - MAX_D;

      unique case (cfg.display_mode)
         MODE_BAR: begin
            pipe_in[0].desc.is_bar = 1'b1;
         end
         MODE_RED_GREEN: begin
            pipe_in[0].desc.hi    = SPAN_ALL;
            pipe_in[0].desc.red   = lt_thr ? COLOUR_FULL : COLOUR_NONE;
            pipe_in[0].desc.green = lt_thr ? COLOUR_NONE : COLOUR_FULL;
         end
         MODE_RED_YELLOW_GREEN: begin
            pipe_in[0].desc.hi    = SPAN_ALL;
            pipe_in[0].desc.red   = (lt_thr || lt_m2) ? COLOUR_FULL : COLOUR_NONE;
            pipe_in[0].desc.green = lt_thr ? COLOUR_NONE : COLOUR_FULL;
         end
         MODE_STOPLIGHT: begin
            if (lt_thr) begin
               pipe_in[0].desc.lo  = (FLIP != 0) ? SPAN_ZERO : SPAN_3S;
               pipe_in[0].desc.hi  = (FLIP != 0) ? SPAN_S : SPAN_ALL;
               pipe_in[0].desc.red = COLOUR_FULL;
            end else if (lt_m2) begin
               pipe_in[0].desc.lo    = SPAN_2S_M1;
               pipe_in[0].desc.hi    = SPAN_3S_M1;
               pipe_in[0].desc.red   = COLOUR_FULL;
               pipe_in[0].desc.green = COLOUR_FULL;
            end else begin
               pipe_in[0].desc.lo    = (FLIP != 0) ? SPAN_3S : SPAN_ZERO;
               pipe_in[0].desc.hi    = (FLIP != 0) ? SPAN_ALL : SPAN_S;
               pipe_in[0].desc.green = COLOUR_FULL;
            end
         end
         default: begin
         end
      endcase

      pipe_in[0].red_div.zero       = red_num[NW-1] || (red_num == '0);
      pipe_in[0].red_div.sat        = red_num >= SAT_LIM;
      pipe_in[0].red_div.dividend   = red_num[DVD_W-1:0];
      pipe_in[0].red_div.quo        = '0;
      pipe_in[0].green_div.zero     = green_num[NW-1] || (green_num == '0);
      pipe_in[0].green_div.sat      = green_num >= SAT_LIM;
      pipe_in[0].green_div.dividend = green_num[DVD_W-1:0];
      pipe_in[0].green_div.quo      = '0;
   end

   // quotient by reciprocal multiplication, exact below 256 * MAX_DISTANCE
   always_comb begin
      red_prod   = PROD_W'(pipe_ff[STEPS-1].red_div.dividend) * PROD_W'(RECIP);
      green_prod = PROD_W'(pipe_ff[STEPS-1].green_div.dividend) * PROD_W'(RECIP);
      pipe_in[STEPS]               = pipe_ff[STEPS-1];
      pipe_in[STEPS].red_div.quo   = red_prod[RECIP_SHIFT +: COLOUR_W];
      pipe_in[STEPS].green_div.quo = green_prod[RECIP_SHIFT +: COLOUR_W];
   end

   always_comb begin
      push_valid = pipe_v_ff[STEPS];
      push_desc  = pipe_ff[STEPS].desc;
      if (pipe_ff[STEPS].desc.is_bar) begin
         push_desc.red   = pipe_ff[STEPS].red_div.zero ? COLOUR_NONE :
                           pipe_ff[STEPS].red_div.sat ? COLOUR_FULL :
                           pipe_ff[STEPS].red_div.quo;
         push_desc.green = pipe_ff[STEPS].green_div.zero ? COLOUR_NONE :
                           pipe_ff[STEPS].green_div.sat ? COLOUR_FULL :
                           pipe_ff[STEPS].green_div.quo;
      end
   end

endmodule

`default_nettype wire

// ===== design/dlbp_queue.sv =====
// Short descriptor queue between the front end and the pixel sequencer.
// Depends on dlbp_pkg.
`default_nettype none

module dlbp_queue #(
   parameter int unsigned DEPTH = dlbp_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  dlbp_pkg::desc_type push_desc,
   output logic               head_valid,
   output dlbp_pkg::desc_type head_desc,
   input  logic               head_pop
);
   import dlbp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   desc_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_FULL;
   assign head_valid = count_ff != '0;
   assign head_desc  = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

// ===== design/dlbp_back.sv =====
// Pixel sequencer: walks a frame descriptor over every LED, one pixel per cycle
// unless stalled, into a response register. Depends on dlbp_pkg and dlbp_rsp_if.
`default_nettype none

module dlbp_back #(
   parameter int unsigned LED_COUNT = dlbp_pkg::LED_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  dlbp_pkg::desc_type head_desc,
   output logic               head_pop,
   input  logic [dlbp_pkg::LEVEL_W-1:0] level,
   dlbp_rsp_if.source         rsp_if
);
   import dlbp_pkg::*;

   localparam logic [INDEX_W-1:0] INDEX_LAST = INDEX_W'(LED_COUNT - 1);

   logic [INDEX_W-1:0]      k_ff;
   logic [INDEX_W-1:0]      k_in;
   logic signed [NUM_W-1:0] acc_ff;
   logic signed [NUM_W-1:0] acc_in;
   logic                    rsp_v_ff;
   logic                    rsp_v_in;
   logic [INDEX_W-1:0]      pix_ff;
   logic [COLOUR_W-1:0]     red_ff;
   logic [COLOUR_W-1:0]     red_in;
   logic [COLOUR_W-1:0]     green_ff;
   logic [COLOUR_W-1:0]     green_in;
   logic [LEVEL_W-1:0]      level_ff;
   logic                    last_ff;

   logic                    emit;
   logic                    at_last;
   logic                    lit;
   logic                    bar_hit;
   logic signed [NUM_W-1:0] num_s;
   logic signed [DEN_W-1:0] den_s;
   logic [SPAN_W-1:0]       k_span;

   assign emit     = head_valid && (!rsp_v_ff || rsp_if.ready);
   assign at_last  = k_ff == INDEX_LAST;
   assign head_pop = emit && at_last;

   always_comb begin
      num_s  = head_desc.num;
      den_s  = head_desc.den;
      k_span = SPAN_W'(k_ff);

      if (den_s == '0 || k_ff == '0) begin
         bar_hit = 1'b1;
      end else if (den_s[DEN_W-1]) begin
         bar_hit = num_s <= acc_ff;
      end else begin
         bar_hit = num_s >= acc_ff;
      end

      lit      = head_desc.is_bar ? bar_hit
                                  : (k_span >= head_desc.lo) && (k_span < head_desc.hi);
      red_in   = lit ? head_desc.red : COLOUR_NONE;
      green_in = lit ? head_desc.green : COLOUR_NONE;

      k_in     = k_ff;
      acc_in   = acc_ff;
      rsp_v_in = rsp_v_ff && !rsp_if.ready;
      if (emit) begin
         rsp_v_in = 1'b1;
         if (at_last) begin
            k_in   = '0;
            acc_in = '0;
         end else begin
            k_in   = k_ff + 1'b1;
            acc_in = acc_ff + NUM_W'(den_s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         acc_ff   <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         acc_ff   <= acc_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pix_ff   <= k_ff;
         red_ff   <= red_in;
         green_ff <= green_in;
         level_ff <= level;
         last_ff  <= at_last;
      end
   end

   assign rsp_if.valid       = rsp_v_ff;
   assign rsp_if.pixel_index = pix_ff;
   assign rsp_if.red         = red_ff;
   assign rsp_if.green       = green_ff;
   assign rsp_if.blue        = COLOUR_NONE;
   assign rsp_if.level       = level_ff;
   assign rsp_if.last        = last_ff;

endmodule

`default_nettype wire

// ===== design/distance_led_bar_pattern_unit.sv =====
// Distance LED bar pattern unit, top level: configuration registers, front end,
// descriptor queue and pixel sequencer. Depends on dlbp_pkg, dlbp_req_if, dlbp_rsp_if,
// dlbp_front, dlbp_queue and dlbp_back.
//
// Usage:
//   Each request carries one distance sample in cm. The unit answers with LED_COUNT
//   responses, pixel_index 0 to LED_COUNT-1 in order, last set on the final one.
//   The csr port writes display_mode, brightness and park_distance; write them only
//   while no frame is in flight.
// Timing:
//   The first pixel passes the sample, classify and multiply registers, the queue
//   and the response register. The pixel sequencer emits one pixel per cycle while
//   rsp ready is high. The front end is a three-stage pipeline (sample register,
//   classify, reciprocal multiply) and keeps taking requests while a frame drains,
//   until the queue fills.
// Reset:
//   Synchronous reset empties the pipeline and queue and loads the register defaults.
// Backpressure:
//   With rsp ready low the pixel holds in its output register; the sequencer, then
//   the queue, then the front end stall in turn and req ready drops.
`default_nettype none

module distance_led_bar_pattern_unit #(
   parameter int unsigned LED_COUNT    = dlbp_pkg::LED_COUNT_DEF,
   parameter int unsigned MAX_DISTANCE = dlbp_pkg::MAX_DISTANCE_DEF,
   parameter int unsigned GUARD_BAND   = dlbp_pkg::GUARD_BAND_DEF,
   parameter int unsigned FLIP         = dlbp_pkg::FLIP_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   dlbp_req_if.sink                          req_if,
   dlbp_rsp_if.source                        rsp_if,
   input  logic                              csr_write_enable,
   input  logic [dlbp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dlbp_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import dlbp_pkg::*;

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     push_valid;
   logic     push_ready;
   desc_type push_desc;
   logic     head_valid;
   desc_type head_desc;
   logic     head_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DISPLAY_MODE:  cfg_in.display_mode  = csr_write_data[MODE_W-1:0];
            CSR_BRIGHTNESS:    cfg_in.brightness    = csr_write_data[LEVEL_W-1:0];
            CSR_PARK_DISTANCE: cfg_in.park_distance = csr_write_data[PARK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_mode  <= DISPLAY_MODE_RESET;
         cfg_ff.brightness    <= BRIGHTNESS_RESET;
         cfg_ff.park_distance <= PARK_DISTANCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dlbp_front #(
      .LED_COUNT    (LED_COUNT),
      .MAX_DISTANCE (MAX_DISTANCE),
      .GUARD_BAND   (GUARD_BAND),
      .FLIP         (FLIP)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc)
   );

   dlbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .head_pop   (head_pop)
   );

   dlbp_back #(
      .LED_COUNT (LED_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .head_pop   (head_pop),
      .level      (cfg_ff.brightness),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

// ===== design/dlbp_checker.sv =====
// Port-level checks for the distance LED bar pattern unit, bound to its top level.
// Depends on distance_led_bar_pattern_unit.
`default_nettype none

module dlbp_checker #(
   parameter int unsigned LED_COUNT = dlbp_pkg::LED_COUNT_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [dlbp_pkg::INDEX_W-1:0] rsp_pixel_index,
   input logic                         rsp_last
);
   import dlbp_pkg::*;

   localparam logic [INDEX_W-1:0] INDEX_LAST = INDEX_W'(LED_COUNT - 1);

   logic [INDEX_W-1:0] exp_index_ff;
   logic [INDEX_W-1:0] exp_index_in;

   assign exp_index_in = (rsp_valid && rsp_ready) ?
                         (rsp_last ? '0 : exp_index_ff + 1'b1) : exp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_index_ff <= '0;
      end else begin
         exp_index_ff <= exp_index_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_index))
      else $error("pixel changed while stalled");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_pixel_index == INDEX_LAST)))
      else $error("last flag does not match final pixel");

   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_index == exp_index_ff)
      else $error("pixel index out of order");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind distance_led_bar_pattern_unit dlbp_checker #(
   .LED_COUNT (LED_COUNT)
) u_dlbp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_pixel_index (rsp_if.pixel_index),
   .rsp_last        (rsp_if.last)
);

`default_nettype wire

// ===== verif/tb_distance_led_bar_pattern_unit.sv =====
// Testbench for distance_led_bar_pattern_unit: predicts every pixel of each frame and checks
// each response in order while both channels idle and stall at random.
// Depends on dlbp_pkg, dlbp_req_if, dlbp_rsp_if and the unit itself.
`default_nettype none

module tb_distance_led_bar_pattern_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import dlbp_pkg::*;

   localparam int  LEDS         = int'(LED_COUNT_DEF);
   localparam int  MAX_DIST     = int'(MAX_DISTANCE_DEF);
   localparam int  SAFE         = int'(GUARD_BAND_DEF);
   localparam bit  FLIPPED      = (FLIP_DEF != 0);
   localparam int  COLOUR_SPAN  = 510;
   localparam int  IDLE_PCT     = 36;
   localparam int  HOLD_CYCLES  = 400;
   localparam int  SETTLE       = 40;
   localparam int  CYCLE_LIMIT  = 200000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct packed {
      logic [INDEX_W-1:0]  pixel_index;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
      logic [LEVEL_W-1:0]  level;
      logic                last;
   } pixel_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_idx;
   logic [CSR_DATA_W-1:0]  csr_data;

   dlbp_req_if req_bus ();
   dlbp_rsp_if rsp_bus ();

   distance_led_bar_pattern_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_we),
      .csr_index        (csr_idx),
      .csr_write_data   (csr_data)
   );

   logic [MODE_W-1:0]  cfg_mode;
   logic [LEVEL_W-1:0] cfg_level;
   logic [PARK_W-1:0]  cfg_park;

   pixel_type pending_pixels[$];
   int        idle_pct = IDLE_PCT;
   bit        hold_toggle = 1'b0;
   int        error_count = 0;
   int        samples_sent = 0;
   int        pixels_checked = 0;
   int        settings_applied = 0;
   int        cycle_count = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
               pending_pixels.size());
      $display("FAILURE");
      $finish;
   end

   function automatic int colour_level(input longint num);
      longint q;
      if (num <= 0)
         return 0;
      q = num / MAX_DIST;
      return (q > 255) ? 255 : int'(q);
   endfunction

   function automatic void predict_frame(input logic [DIST_W-1:0] distance);
      longint    sample, thr, span, den, lit, d;
      int        third, bar_red, bar_green, k;
      pixel_type px;
      sample = longint'(distance);
      thr    = longint'(SAFE) + longint'(cfg_park);
      span   = MAX_DIST - thr;
      third  = (LEDS - 2) / 3;
      den    = thr - MAX_DIST;
      d      = sample - thr;
      lit    = LEDS;
      if (den != 0) begin
         lit = (longint'(LEDS - 1) * (sample - MAX_DIST)) / den + 1;
         if (lit < 1)
            lit = 1;
         if (lit > LEDS)
            lit = LEDS;
      end
      bar_red   = colour_level(COLOUR_SPAN * (MAX_DIST - d));
      bar_green = colour_level(COLOUR_SPAN * d);
      for (k = 0; k < LEDS; k++) begin
         px             = '0;
         px.pixel_index = INDEX_W'(k);
         px.level       = cfg_level;
         px.last        = (k == LEDS - 1);
         case (cfg_mode)
            MODE_BAR: begin
               if (k < lit) begin
                  px.red   = COLOUR_W'(bar_red);
                  px.green = COLOUR_W'(bar_green);
               end
            end
            MODE_RED_GREEN: begin
               if (sample < thr)
                  px.red = COLOUR_FULL;
               else
                  px.green = COLOUR_FULL;
            end
            MODE_RED_YELLOW_GREEN: begin
               if (sample < thr) begin
                  px.red = COLOUR_FULL;
               end else if (sample < span) begin
                  px.red   = COLOUR_FULL;
                  px.green = COLOUR_FULL;
               end else begin
                  px.green = COLOUR_FULL;
               end
            end
            MODE_STOPLIGHT: begin
               if (sample < thr) begin
                  if (FLIPPED ? (k < third) : (k >= 3 * third))
                     px.red = COLOUR_FULL;
               end else if (sample < span) begin
                  if (k >= 2 * third - 1 && k < 3 * third - 1) begin
                     px.red   = COLOUR_FULL;
                     px.green = COLOUR_FULL;
                  end
               end else begin
                  if (FLIPPED ? (k >= 3 * third) : (k < third))
                     px.green = COLOUR_FULL;
               end
            end
            default: ;
         endcase
         pending_pixels.push_back(px);
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   task automatic check_pixel();
      pixel_type want;
      if (pending_pixels.size() == 0) begin
         report_mismatch("unexpected pixel, index", rsp_bus.pixel_index, 0);
      end else begin
         want = pending_pixels.pop_front();
         pixels_checked++;
         if (rsp_bus.pixel_index !== want.pixel_index)
            report_mismatch("pixel_index", rsp_bus.pixel_index, want.pixel_index);
         if (rsp_bus.red !== want.red)
            report_mismatch("red", rsp_bus.red, want.red);
         if (rsp_bus.green !== want.green)
            report_mismatch("green", rsp_bus.green, want.green);
         if (rsp_bus.blue !== want.blue)
            report_mismatch("blue", rsp_bus.blue, want.blue);
         if (rsp_bus.level !== want.level)
            report_mismatch("level", rsp_bus.level, want.level);
         if (rsp_bus.last !== want.last)
            report_mismatch("last", rsp_bus.last, want.last);
      end
   endtask

   always @(posedge clock)
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         check_pixel();

   initial begin
      int  hold_left;
      bit  hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   task automatic send_distance(input logic [DIST_W-1:0] distance);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.distance <= distance;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predict_frame(distance);
      samples_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we   <= 1'b1;
      csr_idx  <= idx;
      csr_data <= data;
      case (idx)
         CSR_DISPLAY_MODE:  cfg_mode  = data[MODE_W-1:0];
         CSR_BRIGHTNESS:    cfg_level = data[LEVEL_W-1:0];
         CSR_PARK_DISTANCE: cfg_park  = data[PARK_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] mode_word,
                            input logic [CSR_DATA_W-1:0] level_word,
                            input logic [CSR_DATA_W-1:0] park);
      drain();
      write_reg(CSR_DISPLAY_MODE, mode_word);
      write_reg(CSR_BRIGHTNESS, level_word);
      write_reg(CSR_PARK_DISTANCE, park);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   task automatic test_default_registers();
      send_distance(10'd0);
      send_distance(10'd1023);
      send_distance(10'd40);
   endtask

   task automatic test_display_modes();
      configure(10'h3F8 | CSR_DATA_W'(MODE_RED_GREEN), 10'd77, 10'd30);
      send_distance(10'd39);
      send_distance(10'd40);
      configure(CSR_DATA_W'(MODE_RED_YELLOW_GREEN), 10'h300, 10'd30);
      send_distance(10'd39);
      send_distance(10'd40);
      send_distance(10'd159);
      send_distance(10'd160);
      configure(CSR_DATA_W'(MODE_STOPLIGHT), 10'd200, 10'd30);
      send_distance(10'd39);
      send_distance(10'd40);
      send_distance(10'd159);
      send_distance(10'd160);
      configure(CSR_DATA_W'(MODE_OFF), 10'd1, 10'd30);
      send_distance(10'd100);
      configure(10'h3FF, 10'h3FF, 10'd30);
      send_distance(10'd5);
   endtask

   task automatic test_bar_edges();
      configure(CSR_DATA_W'(MODE_BAR), 10'd0, 10'd190);
      send_distance(10'd0);
      send_distance(10'd1023);
      configure(CSR_DATA_W'(MODE_BAR), 10'd128, 10'd0);
      send_distance(10'd0);
      configure(CSR_DATA_W'(MODE_BAR), 10'd64, 10'd1023);
      send_distance(10'd1023);
   endtask

   task automatic test_ignored_index();
      configure(CSR_DATA_W'(MODE_RED_GREEN), 10'd33, 10'd30);
      write_reg(CSR_SPARE_INDEX, 10'd0);
      csr_we <= 1'b0;
      send_distance(10'd39);
   endtask

   task automatic test_backpressure_fill();
      int k;
      drain();
      hold_toggle = ~hold_toggle;
      for (k = 0; k < 12; k++)
         send_distance(DIST_W'($urandom_range(0, 1023)));
   endtask

   task automatic test_full_rate();
      int k;
      drain();
      idle_pct = 0;
      for (k = 0; k < 16; k++)
         send_distance(DIST_W'($urandom_range(0, 250)));
      drain();
      idle_pct = IDLE_PCT;
   endtask

   task automatic test_random_settings();
      int                    phase, k;
      logic [MODE_W-1:0]     mode;
      logic [CSR_DATA_W-1:0] park;
      for (phase = 0; phase < 8; phase++) begin
         if ($urandom_range(0, 3) == 0)
            mode = MODE_W'($urandom_range(MODE_OFF, 7));
         else
            mode = MODE_W'($urandom_range(MODE_BAR, MODE_STOPLIGHT));
         case ($urandom_range(0, 3))
            0:       park = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            1:       park = CSR_DATA_W'($urandom_range(0, 1023));
            default: park = CSR_DATA_W'($urandom_range(0, 120));
         endcase
         configure(CSR_DATA_W'(($urandom_range(0, 127) << MODE_W) | mode),
                   CSR_DATA_W'($urandom_range(0, 1023)), park);
         for (k = 0; k < 10; k++)
            send_distance(DIST_W'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 250)));
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.distance <= '0;
      csr_we           <= 1'b0;
      csr_idx          <= '0;
      csr_data         <= '0;
      cfg_mode  = DISPLAY_MODE_RESET;
      cfg_level = BRIGHTNESS_RESET;
      cfg_park  = PARK_DISTANCE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_registers();
      test_display_modes();
      test_bar_edges();
      test_ignored_index();
      test_backpressure_fill();
      test_full_rate();
      test_random_settings();

      drain();
      repeat (SETTLE) @(posedge clock);
      $display("run covered %0d distance samples, %0d pixels checked, %0d register settings",
               samples_sent, pixels_checked, settings_applied);
      $display("all display modes, zero bar divisor, ignored register index, long stall");
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/dlbp_pkg.sv
design/dlbp_req_if.sv
design/dlbp_rsp_if.sv
design/dlbp_front.sv
design/dlbp_queue.sv
design/dlbp_back.sv
design/distance_led_bar_pattern_unit.sv
design/dlbp_checker.sv
verif/tb_distance_led_bar_pattern_unit.sv
